[src/rssd_pkg.sv]
package rssd_pkg;

	// Default pen coordinate width
	localparam int COORD_BITS_DEFAULT = 13;

	// Fixed field widths
	localparam int SPAN_X_W   = 13;
	localparam int SPAN_Y_W   = 12;
	localparam int WIDTH_W    = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET = 13'd64;
	localparam logic [SPAN_Y_W-1:0] Y_MAX       = 12'hFFF;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_REFLECT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHADOW_OFF = 2'd2;

	// Stream codes
	localparam logic [7:0] CODE_EOL      = 8'h00;
	localparam logic [7:0] CODE_LIT_LO   = 8'h01;
	localparam logic [7:0] CODE_LIT_HI   = 8'h7F;
	localparam logic [7:0] CODE_END      = 8'h80;
	localparam logic [7:0] CODE_SKIP_LO  = 8'h81;
	localparam logic [7:0] CODE_SKIP_HI  = 8'hBF;
	localparam logic [7:0] CODE_SHADOW   = 8'hC0;
	localparam logic [7:0] CODE_FILL     = 8'hC1;
	localparam logic [7:0] SKIP_BASE     = 8'h80;
	localparam logic [7:0] SHORT_BASE    = 8'hC0;

	typedef enum logic [1:0] {
		KIND_PALETTE = 2'd0,
		KIND_SHADOW  = 2'd1,
		KIND_STATUS  = 2'd2
	} span_kind_t;

endpackage

[src/rle_sprite_span_decoder_unit.sv]
// A request passes through the input register, then one pass of phase/pen logic into
// the result register. Throughput: one byte per cycle unless out_stall holds a result,
// bounded by the single pen adder and phase update that close each cycle; bytes that
// give no result still take a slot.
// Reset (arst_n low, asynchronous): registers to reset values, pen at line
// start, parse phase waiting for a command byte, both stages empty.
module rle_sprite_span_decoder_unit #(
	parameter int COORD_BITS = rssd_pkg::COORD_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// byte stream
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        data_byte,
	input  logic                              end_of_buffer,
	// span results
	output logic                              out_valid,
	input  logic                              out_stall,
	output rssd_pkg::span_kind_t              span_kind,
	output logic signed [rssd_pkg::SPAN_X_W-1:0] span_x,
	output logic [rssd_pkg::SPAN_Y_W-1:0]     span_y,
	output logic [7:0]                        span_length,
	output logic [7:0]                        color_index,
	output logic                              image_done,
	output logic                              truncated,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rssd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rssd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		PH_CMD,
		PH_LIT,
		PH_SH_FIRST,
		PH_SH_SECOND,
		PH_FILL_COUNT,
		PH_FILL_VALUE,
		PH_SHORT_VALUE,
		PH_DONE
	} phase_t;

	// Line start for a given mode and width: 0, or width-1 wrapped to the pen width.
	function automatic logic [COORD_BITS-1:0] line_start(
		input logic                          refl,
		input logic [rssd_pkg::WIDTH_W-1:0] width
	);
		logic [COORD_BITS+rssd_pkg::WIDTH_W-1:0] wm1;
		wm1 = {{COORD_BITS{1'b0}}, width} - 1'b1;
		return refl ? wm1[COORD_BITS-1:0] : '0;
	endfunction

	// Configuration registers
	logic                         reflect_q;
	logic [rssd_pkg::WIDTH_W-1:0] width_q;
	logic                         shadow_off_q;

	// Decoder state
	phase_t                          phase_q;
	logic [7:0]                      run_q;
	logic [7:0]                      pend_q;
	logic [COORD_BITS-1:0]           pen_x_q;
	logic [rssd_pkg::SPAN_Y_W-1:0]   pen_y_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;

	// Result register
	logic                                 out_valid_q;
	rssd_pkg::span_kind_t                 kind_q;
	logic signed [rssd_pkg::SPAN_X_W-1:0] x_q;
	logic [rssd_pkg::SPAN_Y_W-1:0]        y_q;
	logic [7:0]                           len_q;
	logic [7:0]                           col_q;
	logic                                 done_q;
	logic                                 trunc_q;

	// Stage 1 moves on whenever the result register is free or being drained.
	logic out_free;
	logic step;
	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign cfg_ready = 1'b1;

	// Single-pass decode of the byte held in stage 1
	phase_t                        phase_d;
	logic [7:0]                    run_d;
	logic [7:0]                    pend_d;
	logic [COORD_BITS-1:0]         pen_x_d;
	logic [rssd_pkg::SPAN_Y_W-1:0] pen_y_d;
	logic                          span_en;
	rssd_pkg::span_kind_t          span_k;
	logic [7:0]                    span_col;
	logic                          adv_en;
	logic [7:0]                    adv_n;
	logic                          newline;
	logic                          end_code;
	logic                          done;
	logic                          trunc;
	logic [7:0]                    run_dec;
	logic [COORD_BITS-1:0]         pen_adv;
	logic [COORD_BITS+rssd_pkg::SPAN_X_W-1:0] x_ext;

	assign run_dec = run_q - 8'd1;
	assign pen_adv = reflect_q ? (pen_x_q - COORD_BITS'(adv_n))
	                           : (pen_x_q + COORD_BITS'(adv_n));
	assign x_ext   = {{rssd_pkg::SPAN_X_W{pen_x_q[COORD_BITS-1]}}, pen_x_q};

	always_comb begin
		phase_d  = phase_q;
		run_d    = run_q;
		pend_d   = pend_q;
		span_en  = 1'b0;
		span_k   = rssd_pkg::KIND_PALETTE;
		span_col = '0;
		adv_en   = 1'b0;
		adv_n    = '0;
		newline  = 1'b0;
		end_code = 1'b0;
		case (phase_q)
			PH_CMD: begin
				if (byte_s1 == rssd_pkg::CODE_EOL) begin
					newline = 1'b1;
				end else if (byte_s1 inside {[rssd_pkg::CODE_LIT_LO:rssd_pkg::CODE_LIT_HI]}) begin
					run_d   = byte_s1;
					phase_d = PH_LIT;
				end else if (byte_s1 == rssd_pkg::CODE_END) begin
					end_code = 1'b1;
				end else if (byte_s1 inside {[rssd_pkg::CODE_SKIP_LO:rssd_pkg::CODE_SKIP_HI]}) begin
					adv_en = 1'b1;
					adv_n  = byte_s1 - rssd_pkg::SKIP_BASE;
				end else if (byte_s1 == rssd_pkg::CODE_SHADOW) begin
					phase_d = PH_SH_FIRST;
				end else if (byte_s1 == rssd_pkg::CODE_FILL) begin
					phase_d = PH_FILL_COUNT;
				end else begin
					pend_d  = byte_s1 - rssd_pkg::SHORT_BASE;
					phase_d = PH_SHORT_VALUE;
				end
			end
			PH_LIT: begin
				span_en  = 1'b1;
				adv_n    = 8'd1;
				span_col = byte_s1;
				run_d    = run_dec;
				if (run_dec == 8'd0) begin
					phase_d = PH_CMD;
				end
			end
			PH_SH_FIRST: begin
				if (byte_s1[1:0] != 2'd0) begin
					adv_n   = {6'd0, byte_s1[1:0]};
					span_en = !shadow_off_q;
					adv_en  = shadow_off_q;
					span_k  = rssd_pkg::KIND_SHADOW;
					phase_d = PH_CMD;
				end else begin
					phase_d = PH_SH_SECOND;
				end
			end
			PH_SH_SECOND: begin
				adv_n   = byte_s1;
				span_en = !shadow_off_q && (byte_s1 != 8'd0);
				adv_en  = shadow_off_q;
				span_k  = rssd_pkg::KIND_SHADOW;
				phase_d = PH_CMD;
			end
			PH_FILL_COUNT: begin
				pend_d  = byte_s1;
				phase_d = PH_FILL_VALUE;
			end
			PH_FILL_VALUE, PH_SHORT_VALUE: begin
				adv_n    = pend_q;
				span_en  = (pend_q != 8'd0);
				span_col = byte_s1;
				phase_d  = PH_CMD;
			end
			default: begin
				// image ended: drop the byte
			end
		endcase

		done  = end_code || eob_s1;
		trunc = eob_s1 && !end_code;
		if (done) begin
			phase_d = PH_DONE;
		end

		pen_x_d = pen_x_q;
		pen_y_d = pen_y_q;
		if (newline) begin
			pen_x_d = line_start(reflect_q, width_q);
			if (pen_y_q != rssd_pkg::Y_MAX) begin
				pen_y_d = pen_y_q + 1'b1;
			end
		end else if (span_en || adv_en) begin
			pen_x_d = pen_adv;
		end
	end

	// Configuration registers; reflect and width writes move the pen to the new line start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reflect_q    <= 1'b0;
			width_q      <= rssd_pkg::WIDTH_RESET;
			shadow_off_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rssd_pkg::REG_REFLECT:    reflect_q    <= cfg_data[0];
				rssd_pkg::REG_WIDTH:      width_q      <= cfg_data[rssd_pkg::WIDTH_W-1:0];
				rssd_pkg::REG_SHADOW_OFF: shadow_off_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input stage: take a new byte whenever the stage is empty or moving on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			run_q   <= '0;
			pend_q  <= '0;
			pen_x_q <= line_start(1'b0, rssd_pkg::WIDTH_RESET);
			pen_y_q <= '0;
		end else if (cfg_valid && cfg_ready && cfg_index == rssd_pkg::REG_REFLECT) begin
			pen_x_q <= line_start(cfg_data[0], width_q);
		end else if (cfg_valid && cfg_ready && cfg_index == rssd_pkg::REG_WIDTH) begin
			pen_x_q <= line_start(reflect_q, cfg_data[rssd_pkg::WIDTH_W-1:0]);
		end else if (step && phase_q != PH_DONE) begin
			phase_q <= phase_d;
			run_q   <= run_d;
			pend_q  <= pend_d;
			pen_x_q <= pen_x_d;
			pen_y_q <= pen_y_d;
		end
	end

	// Result register: a span, or a status-only result when the image ends.
	logic emit;
	assign emit = step && (phase_q != PH_DONE) && (span_en || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			done_q  <= done;
			trunc_q <= trunc;
			if (span_en) begin
				kind_q <= span_k;
				x_q    <= x_ext[rssd_pkg::SPAN_X_W-1:0];
				y_q    <= pen_y_q;
				len_q  <= adv_n;
				col_q  <= span_col;
			end else begin
				kind_q <= rssd_pkg::KIND_STATUS;
				x_q    <= '0;
				y_q    <= '0;
				len_q  <= '0;
				col_q  <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign span_kind   = kind_q;
	assign span_x      = x_q;
	assign span_y      = y_q;
	assign span_length = len_q;
	assign color_index = col_q;
	assign image_done  = done_q;
	assign truncated   = trunc_q;

endmodule

[tb/sv/span_checker.sv]
module span_checker
	import rssd_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_buffer,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  span_kind_t            span_kind,
	input  logic [SPAN_X_W-1:0]   span_x,
	input  logic [SPAN_Y_W-1:0]   span_y,
	input  logic [7:0]            span_length,
	input  logic [7:0]            color_index,
	input  logic                  image_done,
	input  logic                  truncated,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    faults,
	output int                    spans_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	typedef logic [COORD_BITS-1:0] pen_t;

	typedef enum logic [2:0] {
		P_CMD, P_LIT, P_SHADE_A, P_SHADE_B, P_FILL_N, P_FILL_C, P_SHORT_C, P_ENDED
	} phase_t;

	typedef struct packed {
		span_kind_t            kind;
		logic [SPAN_X_W-1:0]   x;
		logic [SPAN_Y_W-1:0]   y;
		logic [7:0]            len;
		logic [7:0]            col;
		logic                  done;
		logic                  cut;
	} span_rec_t;

	span_rec_t owed_spans[$];

	// decoder mirror
	phase_t                phase;
	logic [7:0]            run_left;
	logic [7:0]            count_held;
	pen_t                  pen;
	logic [SPAN_Y_W-1:0]   row;
	logic                  mirror;
	logic [WIDTH_W-1:0]    width;
	logic                  shade_mute;

	span_rec_t made;
	logic      made_hit;

	function automatic pen_t line_origin();
		return mirror ? pen_t'(32'(width) - 32'd1) : '0;
	endfunction

	task automatic move_pen(input int n);
		pen = mirror ? pen_t'(pen - n) : pen_t'(pen + n);
	endtask

	task automatic lay_span(input span_kind_t k, input logic [7:0] len, input logic [7:0] col);
		logic signed [31:0] wide;
		if (len == 8'd0)
			return;
		wide = $signed(pen);
		made_hit = 1'b1;
		made.kind = k;
		made.x = wide[SPAN_X_W-1:0];
		made.y = row;
		made.len = len;
		made.col = col;
		move_pen(len);
	endtask

	task automatic run_shadow(input logic [7:0] n);
		if (shade_mute)
			move_pen(n);
		else
			lay_span(KIND_SHADOW, n, 8'd0);
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic eob);
		logic ended;
		logic cut;
		if (phase == P_ENDED)
			return;
		ended = 1'b0;
		made_hit = 1'b0;
		made.kind = KIND_STATUS;
		made.x = '0;
		made.y = '0;
		made.len = '0;
		made.col = '0;
		case (phase)
			P_CMD: begin
				if (b == CODE_EOL) begin
					if (row != Y_MAX)
						row++;
					pen = line_origin();
				end else if (b <= CODE_LIT_HI) begin
					run_left = b;
					phase = P_LIT;
				end else if (b == CODE_END) begin
					ended = 1'b1;
				end else if (b <= CODE_SKIP_HI) begin
					move_pen(b - SKIP_BASE);
				end else if (b == CODE_SHADOW) begin
					phase = P_SHADE_A;
				end else if (b == CODE_FILL) begin
					phase = P_FILL_N;
				end else begin
					count_held = b - SHORT_BASE;
					phase = P_SHORT_C;
				end
			end
			P_LIT: begin
				lay_span(KIND_PALETTE, 8'd1, b);
				run_left--;
				if (run_left == 8'd0)
					phase = P_CMD;
			end
			P_SHADE_A: begin
				if (b[1:0] != 2'b00) begin
					run_shadow({6'd0, b[1:0]});
					phase = P_CMD;
				end else begin
					phase = P_SHADE_B;
				end
			end
			P_SHADE_B: begin
				run_shadow(b);
				phase = P_CMD;
			end
			P_FILL_N: begin
				count_held = b;
				phase = P_FILL_C;
			end
			default: begin
				lay_span(KIND_PALETTE, count_held, b);
				phase = P_CMD;
			end
		endcase
		// a buffer end that is not the end code closes the image as truncated
		cut = eob && !ended;
		ended = ended || eob;
		if (ended)
			phase = P_ENDED;
		if (made_hit || ended) begin
			made.done = ended;
			made.cut = cut;
			owed_spans.push_back(made);
		end
	endtask

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_REFLECT: begin
				mirror = data[0];
				pen = line_origin();
			end
			REG_WIDTH: begin
				width = data;
				pen = line_origin();
			end
			REG_SHADOW_OFF: shade_mute = data[0];
			default: ;
		endcase
	endtask

	task automatic restore_state();
		mirror = 1'b0;
		width = WIDTH_RESET;
		shade_mute = 1'b0;
		phase = P_CMD;
		run_left = '0;
		count_held = '0;
		row = '0;
		pen = line_origin();
		owed_spans.delete();
	endtask

	always @(posedge clk or negedge arst_n) begin
		span_rec_t want;
		logic bad;
		if (!arst_n) begin
			restore_state();
		end else begin
			// retire before predicting: a result never belongs to a request of the same edge
			if (out_valid && !out_stall) begin
				if (owed_spans.size() == 0) begin
					faults++;
					if (faults <= REPORT_LIMIT)
						$display("span_checker: unexpected span kind=%0d x=%0d y=%0d len=%0d",
							span_kind, $signed(span_x), span_y, span_length);
				end else begin
					want = owed_spans.pop_front();
					bad = (span_kind !== want.kind) || (span_x !== want.x) ||
						(span_y !== want.y) || (span_length !== want.len) ||
						(color_index !== want.col) || (image_done !== want.done) ||
						(truncated !== want.cut);
					if (bad) begin
						faults++;
						if (faults <= REPORT_LIMIT) begin
							$display("span_checker: want kind=%0d x=%0d y=%0d len=%0d col=%0d done=%0b trunc=%0b",
								want.kind, $signed(want.x), want.y, want.len, want.col,
								want.done, want.cut);
							$display("span_checker: got  kind=%0d x=%0d y=%0d len=%0d col=%0d done=%0b trunc=%0b",
								span_kind, $signed(span_x), span_y, span_length, color_index,
								image_done, truncated);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				decode_byte(data_byte, end_of_buffer);
		end
		spans_owed = owed_spans.size();
	end

endmodule

[tb/sv/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rssd_pkg::*;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 11;
	localparam int IDLE_PCT       = 36;
	localparam int SEGMENTS       = 14;
	// the block is two stages deep; give bytes without a result time to clear
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 8;
	// no handshake at all for this long means the block has hung
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int WIDE_FILLS     = 36;

	// Opening requests: literal run with both colour extremes, end of line,
	// both skip extremes, shadow counts from the first and from the second
	// byte, zero-length shadow and fill runs, full-length fill, short runs
	// at both ends of their code range.
	localparam logic [7:0] PRIMER [24] = '{
		8'h02, 8'hFF, 8'h00,
		CODE_EOL,
		CODE_SKIP_LO, CODE_SKIP_HI,
		CODE_SHADOW, 8'h07,
		CODE_SHADOW, 8'h04, 8'hFF,
		CODE_SHADOW, 8'h00, 8'h00,
		CODE_FILL, 8'h00, 8'h55,
		CODE_FILL, 8'hFF, 8'hAA,
		8'hC2, 8'h12,
		8'hFF, 8'h34
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [7:0]             data_byte = '0;
	logic                   end_of_buffer = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	span_kind_t             span_kind;
	logic signed [SPAN_X_W-1:0] span_x;
	logic [SPAN_Y_W-1:0]    span_y;
	logic [7:0]             span_length;
	logic [7:0]             color_index;
	logic                   image_done;
	logic                   truncated;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int   faults;
	int   spans_owed;
	int   bytes_sent = 0;
	int   idle_cycles = 0;
	// while set, neither side inserts gaps
	logic steady = 1'b0;

	rle_sprite_span_decoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.span_kind     (span_kind),
		.span_x        (span_x),
		.span_y        (span_y),
		.span_length   (span_length),
		.color_index   (color_index),
		.image_done    (image_done),
		.truncated     (truncated),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	span_checker span_watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.span_kind     (span_kind),
		.span_x        (span_x),
		.span_y        (span_y),
		.span_length   (span_length),
		.color_index   (color_index),
		.image_done    (image_done),
		.truncated     (truncated),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.faults        (faults),
		.spans_owed    (spans_owed)
	);

	always #HALF_PERIOD clk = ~clk;

	// Receiver: stall at random, except during the steady stretch.
	always @(posedge clk) begin
		if (steady)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < IDLE_PCT);
	end

	// Watchdog: count edges with no handshake on any channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Offer one request and hold it until the block takes it. Stall is
	// sampled at the falling edge, where it is stable up to the next rising
	// edge. Valid stays high on return; between requests it drops only for a random idle gap.
	task automatic send_byte(input logic [7:0] b, input logic eob);
		logic taken;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_buffer <= eob;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		bytes_sent++;
	endtask

	// Hold the sender until every expected span is out, then give bytes
	// that produce nothing time to leave the pipeline.
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (spans_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the selected registers back to back; drop valid only after the last one.
	task automatic program_regs(input logic refl, input logic [CFG_DATA_W-1:0] wid,
			input logic shad, input logic [2:0] pick);
		logic [CFG_DATA_W-1:0] value [3];
		logic [CFG_IDX_W-1:0]  slot [3];
		logic                  taken;
		value[0] = CFG_DATA_W'(refl);
		value[1] = wid;
		value[2] = CFG_DATA_W'(shad);
		slot[0] = REG_REFLECT;
		slot[1] = REG_WIDTH;
		slot[2] = REG_SHADOW_OFF;
		for (int i = 0; i < 3; i++) begin
			if (pick[i]) begin
				cfg_valid <= 1'b1;
				cfg_index <= slot[i];
				cfg_data <= value[i];
				do begin
					@(negedge clk);
					taken = cfg_ready;
					@(posedge clk);
				end while (!taken);
			end
		end
		cfg_valid <= 1'b0;
	endtask

	// One complete, well-formed command with random content, or now and then
	// a stray byte. The end code is kept out: it would close the image.
	task automatic send_command();
		int         pick;
		int         n;
		logic [7:0] b;
		pick = $urandom_range(99);
		if (pick < 8) begin
			send_byte(CODE_EOL, 1'b0);
		end else if (pick < 30) begin
			// mostly short literal runs, sometimes up to the longest one
			n = ($urandom_range(19) == 0) ? $urandom_range(1, CODE_LIT_HI) : $urandom_range(1, 6);
			send_byte(8'(n), 1'b0);
			repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
		end else if (pick < 40) begin
			send_byte(8'($urandom_range(CODE_SKIP_LO, CODE_SKIP_HI)), 1'b0);
		end else if (pick < 55) begin
			// shadow: count in the first byte, or in a second one when the low bits are zero
			send_byte(CODE_SHADOW, 1'b0);
			b = 8'($urandom_range(255));
			if ($urandom_range(1) == 0)
				b[1:0] = 2'b00;
			send_byte(b, 1'b0);
			if (b[1:0] == 2'b00)
				send_byte(8'($urandom_range(255)), 1'b0);
		end else if (pick < 70) begin
			send_byte(CODE_FILL, 1'b0);
			if ($urandom_range(3) == 0)
				send_byte(8'($urandom_range(3)), 1'b0);
			else
				send_byte(8'($urandom_range(255)), 1'b0);
			send_byte(8'($urandom_range(255)), 1'b0);
		end else if (pick < 93) begin
			send_byte(8'($urandom_range(8'hC2, 8'hFF)), 1'b0);
			send_byte(8'($urandom_range(255)), 1'b0);
		end else begin
			b = 8'($urandom_range(255));
			if (b == CODE_END)
				b = CODE_EOL;
			send_byte(b, 1'b0);
		end
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] wid;
		int                    budget;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening with the registers at their reset values.
		foreach (PRIMER[i])
			send_byte(PRIMER[i], 1'b0);

		// The block decodes a single image per reset, so the whole random part
		// lives in one image: segments of commands, each under new settings.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			settle();
			steady <= (seg >= 3 && seg <= 5);
			case (seg)
				0: program_regs(1'b1, 13'd1, 1'b1, 3'b111);
				1: program_regs(1'b1, 13'd4096, 1'b0, 3'b111);
				2: program_regs(1'b0, 13'd8191, 1'b1, 3'b111);
				// zero width puts the mirrored line start at minus one
				3: program_regs(1'b1, 13'd0, 1'b0, 3'b111);
				default: begin
					case ($urandom_range(5))
						0: wid = 13'd1;
						1: wid = WIDTH_RESET;
						2: wid = 13'd4096;
						3: wid = 13'd0;
						4: wid = 13'd8191;
						default: wid = 13'($urandom_range(1, 4096));
					endcase
					program_regs(1'($urandom_range(1)), wid, 1'($urandom_range(1)),
						3'($urandom_range(1, 7)));
				end
			endcase

			// Drive the pen across the coordinate wrap with a line of long fills.
			if (seg == 5) begin
				repeat (WIDE_FILLS) begin
					send_byte(CODE_FILL, 1'b0);
					send_byte(8'hFF, 1'b0);
					send_byte(8'($urandom_range(255)), 1'b0);
				end
			end

			budget = bytes_sent + $urandom_range(20, 40);
			while (bytes_sent < budget) begin
				send_command();
				// pause now and then until the result queue runs dry
				if ($urandom_range(39) == 0)
					settle();
			end
		end

		// Close the image one of four ways: end code, end code on the last
		// buffer byte, buffer end on a span, buffer end on a command cut short.
		case ($urandom_range(3))
			0: send_byte(CODE_END, 1'b0);
			1: send_byte(CODE_END, 1'b1);
			2: begin
				send_byte(8'($urandom_range(8'hC2, 8'hFF)), 1'b0);
				send_byte(8'($urandom_range(255)), 1'b1);
			end
			default: send_byte(CODE_FILL, 1'b1);
		endcase

		// Bytes after the end must be swallowed without a result.
		repeat (4) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));

		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (spans_owed != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (faults == 0 && spans_owed == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
